// ----- src/best_fit_heap_allocator_core_assert.svh -----
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_core_assert
// Assertion macros for the best-fit heap allocator core.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BFH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BFH_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- src/bfha_pkg.sv -----
// ---------------------------------------------------------------------------
// bfha_pkg
// Types and codes shared by the best-fit heap allocator core.
// ---------------------------------------------------------------------------
package bfha_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] CFG_COMMIT  = 2'd0;
	localparam logic [1:0] CFG_RESERVE = 2'd1;
	localparam logic [1:0] CFG_PAGE    = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [19:0] request_bytes;
		logic [19:0] free_address;
	} in_item_t;

	typedef struct packed {
		logic [19:0] result_address;
		logic [1:0]  status;
		logic [20:0] committed_bytes;
		logic [19:0] commit_offset;
	} out_item_t;

	typedef enum logic [3:0] {
		S_BUILD0, S_BUILD1, S_IDLE,
		S_A_SCAN, S_A_USED, S_A_DEC, S_A_WR0, S_A_WR1,
		S_F_USED, S_F_SCAN, S_F_DEC, S_F_WR0, S_F_WR1,
		S_OUT
	} state_t;

endpackage

// ----- src/best_fit_heap_allocator_core.sv -----
// An allocate scans the free table, picks a used slot, decides and writes both tables;
// a free scans the used table, then the free table, decides and writes; an error skips
// the table write states. One item at a time, with an idle state after each result
// transfer; the table scans read one entry a cycle. Ready is low while an item is in work,
// its result waits to be taken or the tables are built. After reset or a configuration
// write to index 0 to 2 the valid bits are cleared and the initial free entries written.
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Best-fit allocator over committed and reserved free blocks; frees coalesce with committed ones.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_core #(
	parameter int REGION_BITS  = 20,
	parameter int FREE_ENTRIES = 64,
	parameter int USED_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bfha_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bfha_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [20:0]          cfg_wdata
);
	`include "best_fit_heap_allocator_core_assert.svh"

	localparam int FW = $clog2(FREE_ENTRIES);
	localparam int UW = $clog2(USED_ENTRIES);
	localparam int IW = (FW > UW) ? FW : UW;
	localparam int RB = REGION_BITS;
	localparam logic [RB:0] REGION_SIZE = {1'b1, {RB{1'b0}}};
	localparam logic [RB:0] HDR = (RB+1)'(4);

	// Valid bits in flip-flops; entry contents in memories.
	logic [FREE_ENTRIES-1:0] fv_q, fres_q;
	logic [USED_ENTRIES-1:0] uv_q;
	logic [RB-1:0] faddr_mem [FREE_ENTRIES];
	logic [RB:0]   fsize_mem [FREE_ENTRIES];
	logic [RB-1:0] uaddr_mem [USED_ENTRIES];
	logic [RB:0]   usize_mem [USED_ENTRIES];

	logic [20:0] cfg_commit_q, cfg_reserve_q;
	logic [4:0]  cfg_page_q;
	bfha_pkg::state_t state_q, state_d;
	bfha_pkg::in_item_t item_q;
	bfha_pkg::out_item_t res_q, res_d;

	logic [IW:0] idx_q;           // scan counter, read data follows in the next cycle
	logic        rd_ok_s1;
	logic [FW-1:0] rd_idx_s1;
	logic [RB-1:0] rd_faddr_s1;
	logic [RB:0]   rd_fsize_s1;
	logic [UW-1:0] urd_idx_s1;
	logic [RB-1:0] rd_uaddr_s1;
	logic [RB:0]   rd_usize_s1;

	// Scan results.
	logic best_v_q; logic [FW-1:0] best_q; logic [RB-1:0] best_addr_q;
	logic [RB:0] best_size_q; logic best_res_q;
	logic uslot_v_q; logic [UW-1:0] uslot_q;
	logic uslot_v_d; logic [UW-1:0] uslot_d;
	logic umatch_v_q; logic [UW-1:0] umatch_q; logic [RB:0] usz_q;
	logic left_v_q, right_v_q; logic [FW-1:0] left_q, right_q;
	logic [RB-1:0] left_addr_q; logic [RB:0] left_size_q, right_size_q;
	logic fs1_v_q, fs2_v_q; logic [FW-1:0] fs1_q, fs2_q; // two lowest invalid
	logic [RB:0] need_q, csize_q, rest_q;

	// Page size.
	logic [4:0] pb;
	always_comb begin
		pb = cfg_page_q;
		if (pb < 5'd4) pb = 5'd4;
		if (pb > 5'd16) pb = 5'd16;
		if (32'(pb) > RB) pb = 5'(RB);
	end
	function automatic logic [32:0] round_past(input logic [32:0] x, input logic [4:0] p);
		return ((x >> p) + 33'd1) << p;
	endfunction

	// Build values.
	logic [32:0] b_commit, b_reserve;
	always_comb begin
		b_commit = round_past(33'(cfg_commit_q), pb);
		b_reserve = round_past(33'(cfg_reserve_q), pb);
		if (b_reserve > 33'(REGION_SIZE)) b_reserve = 33'(REGION_SIZE);
		if (b_commit > b_reserve) b_commit = b_reserve;
	end

	logic scan_f, scan_u;
	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_index <= bfha_pkg::CFG_PAGE);
	logic [RB-1:0] hdr_addr;
	assign hdr_addr = RB'(item_q.free_address) - RB'(HDR);

	// Next state.
	logic f_done, u_done;
	assign f_done = (idx_q == (IW+1)'(FREE_ENTRIES));
	assign u_done = (idx_q == (IW+1)'(USED_ENTRIES));
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfha_pkg::S_BUILD0: if (f_done) state_d = bfha_pkg::S_BUILD1;
			bfha_pkg::S_BUILD1: state_d = bfha_pkg::S_IDLE;
			bfha_pkg::S_IDLE: if (in_valid)
				state_d = (in_data.operation == bfha_pkg::OP_ALLOC) ?
					bfha_pkg::S_A_SCAN : bfha_pkg::S_F_USED;
			bfha_pkg::S_A_SCAN: if (f_done && !rd_ok_s1) state_d = bfha_pkg::S_A_USED;
			bfha_pkg::S_A_USED: state_d = bfha_pkg::S_A_DEC;
			bfha_pkg::S_A_DEC: state_d = (!best_v_q || !uslot_v_q ||
				(rest_q != '0 && csize_q != need_q && !(fs1_v_q &&
				(fs1_q != best_q || fs2_v_q)))) ? bfha_pkg::S_OUT : bfha_pkg::S_A_WR0;
			bfha_pkg::S_A_WR0: state_d = bfha_pkg::S_A_WR1;
			bfha_pkg::S_A_WR1: state_d = bfha_pkg::S_OUT;
			bfha_pkg::S_F_USED: if (u_done && !rd_ok_s1) state_d = bfha_pkg::S_F_SCAN;
			bfha_pkg::S_F_SCAN: if (f_done && !rd_ok_s1) state_d = bfha_pkg::S_F_DEC;
			bfha_pkg::S_F_DEC: state_d = (!umatch_v_q || (!left_v_q && !right_v_q &&
				!fs1_v_q)) ? bfha_pkg::S_OUT : bfha_pkg::S_F_WR0;
			bfha_pkg::S_F_WR0: state_d = bfha_pkg::S_F_WR1;
			bfha_pkg::S_F_WR1: state_d = bfha_pkg::S_OUT;
			bfha_pkg::S_OUT: if (out_ready) state_d = bfha_pkg::S_IDLE;
			default: state_d = bfha_pkg::S_IDLE;
		endcase
		if (cfg_hit) state_d = bfha_pkg::S_BUILD0;
	end
	assign in_ready = (state_q == bfha_pkg::S_IDLE);
	assign out_valid = (state_q == bfha_pkg::S_OUT);
	assign out_data = res_q;
	assign scan_f = (state_q == bfha_pkg::S_A_SCAN) || (state_q == bfha_pkg::S_F_SCAN);
	assign scan_u = (state_q == bfha_pkg::S_F_USED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfha_pkg::S_BUILD0;
			cfg_commit_q <= 21'd4096;
			cfg_reserve_q <= 21'd65536;
			cfg_page_q <= 5'd12;
			fv_q <= '0; fres_q <= '0; uv_q <= '0;
			idx_q <= '0; rd_ok_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					bfha_pkg::CFG_COMMIT:  cfg_commit_q <= cfg_wdata;
					bfha_pkg::CFG_RESERVE: cfg_reserve_q <= cfg_wdata;
					bfha_pkg::CFG_PAGE:    cfg_page_q <= cfg_wdata[4:0];
					default: ;
				endcase
			end
			if (state_d != state_q || cfg_hit) idx_q <= '0;
			else if ((scan_f && !f_done) || (scan_u && !u_done) ||
				(state_q == bfha_pkg::S_BUILD0 && !f_done)) idx_q <= idx_q + 1'b1;
			rd_ok_s1 <= ((scan_f && !f_done) || (scan_u && !u_done)) &&
				state_d == state_q;
			unique case (state_q)
				bfha_pkg::S_BUILD0: begin
					fv_q <= '0; uv_q <= '0;
				end
				bfha_pkg::S_BUILD1: begin
					fv_q[1:0] <= {b_reserve != b_commit, b_commit != '0};
					fres_q[1:0] <= 2'b10;
				end
				bfha_pkg::S_A_WR0: begin
					fv_q[best_q] <= (rest_q != '0);
					fres_q[best_q] <= 1'b1;
					uv_q[uslot_q] <= 1'b1;
				end
				bfha_pkg::S_A_WR1: if (csize_q != need_q) begin
					if (rest_q != '0) begin
						fv_q[(fs1_q == best_q) ? fs2_q : fs1_q] <= 1'b1;
						fres_q[(fs1_q == best_q) ? fs2_q : fs1_q] <= 1'b0;
					end else begin
						fv_q[(fs1_v_q && fs1_q < best_q) ? fs1_q : best_q] <= 1'b1;
						fres_q[(fs1_v_q && fs1_q < best_q) ? fs1_q : best_q] <= 1'b0;
					end
				end
				bfha_pkg::S_F_WR0: begin
					if (right_v_q) fv_q[right_q] <= 1'b0;
					uv_q[umatch_q] <= 1'b0;
				end
				bfha_pkg::S_F_WR1: begin
					fv_q[left_v_q ? left_q : (right_v_q ? right_q : fs1_q)] <= 1'b1;
					fres_q[left_v_q ? left_q : (right_v_q ? right_q : fs1_q)] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Memory ports: registered reads during scans, writes at build and write states.
	logic [FW-1:0] fw_idx; logic fw_en; logic [RB-1:0] fw_addr; logic [RB:0] fw_size;
	logic [UW-1:0] uw_idx;
	always_comb begin
		fw_en = 1'b0; fw_idx = '0; fw_addr = '0; fw_size = '0;
		uw_idx = uslot_q;
		unique case (state_q)
			bfha_pkg::S_BUILD1: begin fw_en = 1'b1; fw_idx = '0; fw_addr = '0;
				fw_size = (RB+1)'(b_commit); end
			bfha_pkg::S_BUILD0: if (idx_q == '0) begin fw_en = 1'b1;
				fw_idx = FW'(1); fw_addr = RB'(b_commit);
				fw_size = (RB+1)'(b_reserve - b_commit); end
			bfha_pkg::S_A_WR0: begin fw_en = 1'b1; fw_idx = best_q;
				fw_addr = RB'(best_addr_q + RB'(csize_q)); fw_size = rest_q; end
			bfha_pkg::S_A_WR1: begin fw_en = (csize_q != need_q);
				fw_idx = (rest_q != '0) ? ((fs1_q == best_q) ? fs2_q : fs1_q) :
					((fs1_v_q && fs1_q < best_q) ? fs1_q : best_q);
				fw_addr = RB'(best_addr_q + RB'(need_q)); fw_size = csize_q - need_q; end
			bfha_pkg::S_F_WR1: begin fw_en = 1'b1;
				fw_idx = left_v_q ? left_q : (right_v_q ? right_q : fs1_q);
				fw_addr = left_v_q ? left_addr_q : hdr_addr;
				fw_size = usz_q + (left_v_q ? left_size_q : '0) +
					(right_v_q ? right_size_q : '0); end
			default: ;
		endcase
	end
	always_ff @(posedge clk) begin
		if (fw_en) begin faddr_mem[fw_idx] <= fw_addr; fsize_mem[fw_idx] <= fw_size; end
		if (state_q == bfha_pkg::S_A_WR0) begin
			uaddr_mem[uw_idx] <= best_addr_q; usize_mem[uw_idx] <= need_q;
		end
		rd_idx_s1 <= idx_q[FW-1:0];
		rd_faddr_s1 <= faddr_mem[idx_q[FW-1:0]];
		rd_fsize_s1 <= fsize_mem[idx_q[FW-1:0]];
		urd_idx_s1 <= idx_q[UW-1:0];
		rd_uaddr_s1 <= uaddr_mem[idx_q[UW-1:0]];
		rd_usize_s1 <= usize_mem[idx_q[UW-1:0]];
	end

	// Shared compare datapath over the registered read entry.
	logic better;
	logic [RB:0] e_end;
	assign e_end = {1'b0, rd_faddr_s1} + rd_fsize_s1;
	always_comb begin
		better = !best_v_q || rd_fsize_s1 < best_size_q ||
			(rd_fsize_s1 == best_size_q && !fres_q[rd_idx_s1] && best_res_q) ||
			(rd_fsize_s1 == best_size_q && fres_q[rd_idx_s1] == best_res_q &&
			rd_faddr_s1 < best_addr_q);
	end
	logic [32:0] cs_raw;
	assign cs_raw = round_past(33'(need_q), pb);
	logic cs_fits;
	assign cs_fits = best_res_q && (cs_raw <= 33'(best_size_q));

	// Lowest invalid used entry.
	always_comb begin
		uslot_v_d = 1'b0;
		uslot_d = '0;
		for (int i = USED_ENTRIES-1; i >= 0; i--)
			if (!uv_q[i]) begin uslot_v_d = 1'b1; uslot_d = UW'(i); end
	end

	// Result of the decision step.
	always_comb begin
		res_d = '0;
		if (state_q == bfha_pkg::S_A_DEC) begin
			if (!best_v_q) res_d.status = bfha_pkg::ST_NO_SPACE;
			else if (state_d == bfha_pkg::S_OUT) res_d.status = bfha_pkg::ST_FULL;
			else begin
				res_d.status = bfha_pkg::ST_OK;
				res_d.result_address = 20'(RB'(best_addr_q + RB'(4)));
				if (best_res_q) begin
					res_d.committed_bytes = 21'(csize_q);
					res_d.commit_offset = 20'(best_addr_q);
				end
			end
		end else begin
			res_d.status = !umatch_v_q ? bfha_pkg::ST_NOT_ALLOC :
				(state_d == bfha_pkg::S_OUT ? bfha_pkg::ST_FULL : bfha_pkg::ST_OK);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bfha_pkg::S_IDLE) begin
			item_q <= in_data;
			need_q <= (RB+1)'(in_data.request_bytes) + HDR;
			best_v_q <= 1'b0; uslot_v_q <= 1'b0; umatch_v_q <= 1'b0;
			left_v_q <= 1'b0; right_v_q <= 1'b0; fs1_v_q <= 1'b0; fs2_v_q <= 1'b0;
		end
		if ((scan_f) && rd_ok_s1) begin
			if (!fv_q[rd_idx_s1]) begin
				if (!fs1_v_q) begin fs1_v_q <= 1'b1; fs1_q <= rd_idx_s1; end
				else if (!fs2_v_q) begin fs2_v_q <= 1'b1; fs2_q <= rd_idx_s1; end
			end else if (state_q == bfha_pkg::S_A_SCAN) begin
				if (rd_fsize_s1 >= need_q && better) begin
					best_v_q <= 1'b1; best_q <= rd_idx_s1; best_addr_q <= rd_faddr_s1;
					best_size_q <= rd_fsize_s1; best_res_q <= fres_q[rd_idx_s1];
				end
			end else if (!fres_q[rd_idx_s1]) begin
				if ({1'b0, rd_faddr_s1} == {1'b0, hdr_addr} + usz_q) begin
					right_v_q <= 1'b1; right_q <= rd_idx_s1; right_size_q <= rd_fsize_s1;
				end else if (e_end == {1'b0, hdr_addr}) begin
					left_v_q <= 1'b1; left_q <= rd_idx_s1;
					left_addr_q <= rd_faddr_s1; left_size_q <= rd_fsize_s1;
				end
			end
		end
		if (scan_u && rd_ok_s1 && uv_q[urd_idx_s1] && rd_uaddr_s1 == hdr_addr &&
			!umatch_v_q) begin
			umatch_v_q <= 1'b1; umatch_q <= urd_idx_s1; usz_q <= rd_usize_s1;
		end
		if (state_q == bfha_pkg::S_A_USED) begin
			uslot_v_q <= uslot_v_d;
			uslot_q <= uslot_d;
			csize_q <= cs_fits ? (RB+1)'(cs_raw) : best_size_q;
			rest_q <= cs_fits ? best_size_q - (RB+1)'(cs_raw) : '0;
		end
		// Result register.
		if (state_q == bfha_pkg::S_A_DEC || state_q == bfha_pkg::S_F_DEC) res_q <= res_d;
	end

	`BFH_ASSERT_IMP(a_one_side, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`BFH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready && !cfg_we, out_valid && $stable(out_data))
	`BFH_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready && !cfg_we, !in_ready)
endmodule

// ----- tb/sv/best_fit_heap_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_core_tb
// Self-checking testbench for the best-fit heap allocator. A behavioral copy
// of the allocator predicts every result; random allocate and free traffic
// runs across several page and region settings, with random idling on both
// sides of the core.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_core_tb;

	localparam int NFREE = 64;
	localparam int NUSED = 64;
	localparam int HDR = 4;
	localparam longint REGION = 64'd1 << 20;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	// Behavioral allocator: free and used tables plus the expected results.
	class alloc_scoreboard;
		bit f_valid[NFREE];
		longint f_addr[NFREE];
		longint f_size[NFREE];
		bit f_res[NFREE];
		bit u_valid[NUSED];
		longint u_addr[NUSED];
		longint u_size[NUSED];
		longint commit_reg;
		longint reserve_reg;
		int page_reg;
		bfha_pkg::out_item_t pending[$];
		int mismatches;
		longint live[$];

		function int page_shift();
			int p;
			p = page_reg;
			if (p < 4) p = 4;
			if (p > 16) p = 16;
			return p;
		endfunction

		function longint round_past(longint x);
			int pb;
			pb = page_shift();
			return ((x >> pb) + 1) << pb;
		endfunction

		function int open_free(int skip);
			for (int i = 0; i < NFREE; i++)
				if (!f_valid[i] && i != skip) return i;
			return -1;
		endfunction

		function void put_free(int i, longint a, longint s, bit r);
			f_valid[i] = 1;
			f_addr[i] = a % REGION;
			f_size[i] = s;
			f_res[i] = r;
		endfunction

		function void rebuild();
			longint c;
			longint r;
			c = round_past(commit_reg);
			r = round_past(reserve_reg);
			for (int i = 0; i < NFREE; i++) f_valid[i] = 0;
			for (int i = 0; i < NUSED; i++) u_valid[i] = 0;
			live.delete();
			if (r > REGION) r = REGION;
			if (c > r) c = r;
			if (c != 0) put_free(0, 0, c, 0);
			if (r - c != 0) put_free(1, c, r - c, 1);
		endfunction

		function void set_reg(logic [1:0] idx, longint v);
			if (idx == bfha_pkg::CFG_COMMIT) commit_reg = v & 64'h1FFFFF;
			else if (idx == bfha_pkg::CFG_RESERVE) reserve_reg = v & 64'h1FFFFF;
			else if (idx == bfha_pkg::CFG_PAGE) page_reg = int'(v & 31);
			else return;
			rebuild();
		endfunction

		function void reset_regs();
			commit_reg = 4096;
			reserve_reg = 65536;
			page_reg = 12;
			mismatches = 0;
			rebuild();
		endfunction

		function bfha_pkg::out_item_t allocate(longint req);
			bfha_pkg::out_item_t r;
			longint need, a, bs, cs, rest;
			int best, u, s;
			bit rv;
			r = '0;
			need = req + HDR;
			best = -1;
			u = -1;
			for (int i = 0; i < NFREE; i++) begin
				if (!f_valid[i] || f_size[i] < need) continue;
				if (best < 0) begin
					best = i;
					continue;
				end
				if (f_size[i] < f_size[best] ||
						(f_size[i] == f_size[best] && !f_res[i] && f_res[best]) ||
						(f_size[i] == f_size[best] && f_res[i] == f_res[best] &&
						f_addr[i] < f_addr[best]))
					best = i;
			end
			if (best < 0) begin
				r.status = bfha_pkg::ST_NO_SPACE;
				return r;
			end
			for (int i = 0; i < NUSED; i++)
				if (!u_valid[i]) begin
					u = i;
					break;
				end
			if (u < 0) begin
				r.status = bfha_pkg::ST_FULL;
				return r;
			end
			a = f_addr[best];
			bs = f_size[best];
			rv = f_res[best];
			cs = bs;
			rest = 0;
			if (rv) begin
				cs = round_past(need);
				if (cs > bs) cs = bs;
				rest = bs - cs;
			end
			if (rest != 0 && cs - need != 0 && open_free(best) < 0) begin
				r.status = bfha_pkg::ST_FULL;
				return r;
			end
			f_valid[best] = 0;
			if (rest != 0) put_free(best, a + cs, rest, 1);
			if (cs - need != 0) begin
				s = open_free(-1);
				if (s >= 0) put_free(s, a + need, cs - need, 0);
			end
			u_valid[u] = 1;
			u_addr[u] = a;
			u_size[u] = need;
			if (rv) begin
				r.committed_bytes = 21'(cs);
				r.commit_offset = 20'(a);
			end
			r.status = bfha_pkg::ST_OK;
			r.result_address = 20'((a + HDR) % REGION);
			live.push_back((a + HDR) % REGION);
			return r;
		endfunction

		function bfha_pkg::out_item_t release_block(longint fa);
			bfha_pkg::out_item_t r;
			longint hdr, start, sz;
			int u, lft, rgt, slot;
			r = '0;
			hdr = (fa - HDR) & (REGION - 1);
			u = -1;
			lft = -1;
			rgt = -1;
			for (int i = 0; i < NUSED; i++)
				if (u_valid[i] && u_addr[i] == hdr) begin
					u = i;
					break;
				end
			if (u < 0) begin
				r.status = bfha_pkg::ST_NOT_ALLOC;
				return r;
			end
			sz = u_size[u];
			start = hdr;
			for (int i = 0; i < NFREE; i++) begin
				if (!f_valid[i] || f_res[i]) continue;
				if (f_addr[i] == hdr + sz) rgt = i;
				else if (f_addr[i] + f_size[i] == hdr) lft = i;
			end
			if (lft >= 0) slot = lft;
			else if (rgt >= 0) slot = rgt;
			else slot = open_free(-1);
			if (slot < 0) begin
				r.status = bfha_pkg::ST_FULL;
				return r;
			end
			if (lft >= 0) begin
				start = f_addr[lft];
				sz += f_size[lft];
			end
			if (rgt >= 0) begin
				sz += f_size[rgt];
				f_valid[rgt] = 0;
			end
			put_free(slot, start, sz, 0);
			u_valid[u] = 0;
			foreach (live[k])
				if (live[k] == fa) begin
					live.delete(k);
					break;
				end
			r.status = bfha_pkg::ST_OK;
			return r;
		endfunction

		// Notes one accepted input transfer and queues its expected result.
		function void note_input(bfha_pkg::in_item_t it);
			if (it.operation == bfha_pkg::OP_ALLOC) pending.push_back(allocate(it.request_bytes));
			else pending.push_back(release_block(it.free_address));
		endfunction

		// Checks one result transfer against the oldest expectation.
		function void check_result(bfha_pkg::out_item_t got);
			bfha_pkg::out_item_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch expected %p actual %p", exp, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bfha_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	bfha_pkg::out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [20:0] cfg_wdata;

	alloc_scoreboard sb;
	longint cycles;

	best_fit_heap_allocator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and timeout.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Input transfers are noted in the scoreboard and results checked as they happen.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Receiver: random stalls, with runs of no stall.
	initial begin
		int w;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (w != 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// Valid stays high into the next transfer when no idle cycles are drawn.
	task automatic send(bfha_pkg::in_item_t it);
		int w;
		w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (w != 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_alloc(longint req);
		bfha_pkg::in_item_t it;
		it.operation = bfha_pkg::OP_ALLOC;
		it.request_bytes = 20'(req);
		it.free_address = 20'($urandom);
		send(it);
	endtask

	task automatic send_free(longint fa);
		bfha_pkg::in_item_t it;
		it.operation = bfha_pkg::OP_FREE;
		it.request_bytes = 20'($urandom);
		it.free_address = 20'(fa);
		send(it);
	endtask

	// Waits until every expected result has come, then lets the core settle.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, longint v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= 21'(v);
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
		repeat (NFREE + 10) @(posedge clk);
	endtask

	// Mostly allocations of small sizes and frees of live blocks.
	task automatic random_phase(int n);
		int k;
		longint req;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45) begin
				req = (k < 40) ? $urandom_range(0, 3000) : $urandom_range(0, 20'hFFFFC);
				send_alloc(req);
			end else if (k < 90 && sb.live.size() != 0) begin
				send_free(sb.live[$urandom_range(0, sb.live.size() - 1)]);
			end else begin
				send_free($urandom_range(0, 20'hFFFFF));
			end
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = bfha_pkg::CFG_COMMIT;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (NFREE + 10) @(posedge clk);

		// Directed: size extremes, bad frees, a reserved commit, wrapped offsets.
		send_alloc(0);
		send_alloc(20'hFFFFC);
		send_alloc(20'hFFFFF);
		send_alloc(100);
		send_alloc(5000);
		send_free(4);
		send_free(4);
		send_free(0);
		send_free(20'hFFFFF);
		send_free(20'h55555);
		send_free(20'hAAAAA);
		for (int i = 0; i < 8; i++) send_alloc(1 << (i + 2));
		drain();

		// Extreme settings, including the whole region and the smallest page.
		write_reg(bfha_pkg::CFG_RESERVE, 21'h100000);
		write_reg(bfha_pkg::CFG_COMMIT, 21'h100000);
		write_reg(bfha_pkg::CFG_PAGE, 16);
		send_alloc(20'hFFFFC);
		send_alloc(20'hFFFFB);
		send_free(8);
		drain();
		write_reg(bfha_pkg::CFG_PAGE, 31);
		write_reg(bfha_pkg::CFG_COMMIT, 0);
		write_reg(bfha_pkg::CFG_RESERVE, 0);
		send_alloc(0);
		send_alloc(20);
		drain();
		write_reg(bfha_pkg::CFG_PAGE, 0);
		write_reg(bfha_pkg::CFG_RESERVE, 21'h1FFFFF);
		random_phase(300);
		drain();

		// Small pages fill the tables quickly.
		write_reg(bfha_pkg::CFG_PAGE, 4);
		write_reg(bfha_pkg::CFG_COMMIT, 256);
		write_reg(bfha_pkg::CFG_RESERVE, 65536);
		random_phase(400);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(bfha_pkg::CFG_PAGE, $urandom_range(4, 16));
			write_reg(bfha_pkg::CFG_COMMIT, $urandom_range(0, 21'h100000));
			write_reg(bfha_pkg::CFG_RESERVE, $urandom_range(0, 21'h100000));
			random_phase(300);
			drain();
		end

		repeat (500) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
